/* hdl/biu_pkg.sv */
package biu_pkg;

   // default sizes of the frame store and fixed-point format
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 12;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_STEP      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_STEP      = 2'd3;

   localparam logic [8:0]  RST_SOURCE_WIDTH  = 9'd256;
   localparam logic [8:0]  RST_SOURCE_HEIGHT = 9'd256;
   localparam logic [15:0] RST_COL_STEP      = 16'd4096;
   localparam logic [15:0] RST_ROW_STEP      = 16'd4096;

   // opcode carried in tuser
   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   // beat layout
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAPX,
      ST_MAPY,
      ST_EDGE,
      ST_WGT,
      ST_TERM,
      ST_DONE
   } state_type;

   // what the shared multiplier works on in a given cycle
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_POSX,
      MUL_POSY,
      MUL_WGT,
      MUL_TERM
   } mul_op_type;

   typedef struct packed {
      mul_op_type op;
      logic [1:0] k;        // neighbor: bit0 picks right column, bit1 lower row
      logic [1:0] ch;       // 0 red, 1 green, 2 blue
      logic       start;    // query beat taken
      logic       wr;       // write beat taken
      logic       load_out; // move accumulators to the result register
   } ctrl_type;

endpackage

/* hdl/bilinear_image_upscaler_core.sv */
// Write beat: pixel lands in the frame store if inside MAX_WIDTH x MAX_HEIGHT; req_tready stays high.
// Query beat: rsp_tvalid rises as req_tready returns; one query in work at a time. The
// single shared multiplier forms 2 position, 4 weight and 12 channel products, one per cycle,
// with a row clamp step after the position products; then the product drains and the result
// register loads once the output is free.
// Synchronous active-high reset clears control and configuration; the frame store is not cleared.
module bilinear_image_upscaler_core #(
   parameter int MAX_WIDTH  = biu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = biu_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = biu_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // column[11:0], row[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
   input  logic [biu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode[0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [biu_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [biu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [biu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   biu_pkg::ctrl_type ctrl;
   logic              pending;
   logic [7:0]        red_out, green_out, blue_out;

   biu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .opcode    (req_tuser[0]),
      .rsp_tready(rsp_tready),
      .pending   (pending),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .ctrl      (ctrl)
   );

   // stored pixel is red in the top byte, blue in the bottom byte
   biu_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_column(req_tdata[11:0]),
      .req_row   (req_tdata[23:12]),
      .req_pixel ({req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]}),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .red_out   (red_out),
      .green_out (green_out),
      .blue_out  (blue_out)
   );

   assign rsp_tdata = {blue_out, green_out, red_out};

endmodule

/* hdl/biu_ram.sv */
module biu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/biu_seq.sv */
module biu_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                opcode,
   input  logic                rsp_tready,
   input  logic                pending,
   output logic                req_tready,
   output logic                rsp_tvalid,
   output biu_pkg::ctrl_type   ctrl
);

   biu_pkg::state_type state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] ch_ff, ch_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       out_free;
   logic       load;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load     = (state_ff == biu_pkg::ST_DONE) && !pending && out_free;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      ch_in    = ch_ff;
      case (state_ff)
         biu_pkg::ST_IDLE: begin
            if (req_tvalid && opcode == biu_pkg::OPC_QUERY) begin
               state_in = biu_pkg::ST_MAPX;
            end
         end
         biu_pkg::ST_MAPX: state_in = biu_pkg::ST_MAPY;
         biu_pkg::ST_MAPY: state_in = biu_pkg::ST_EDGE;
         biu_pkg::ST_EDGE: begin
            state_in = biu_pkg::ST_WGT;
            k_in     = 2'd0;
            ch_in    = 2'd0;
         end
         biu_pkg::ST_WGT: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = biu_pkg::ST_TERM;
            end
         end
         biu_pkg::ST_TERM: begin
            if (ch_ff == 2'd2) begin
               ch_in = 2'd0;
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = biu_pkg::ST_DONE;
               end
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         biu_pkg::ST_DONE: begin
            if (load) begin
               state_in = biu_pkg::ST_IDLE;
            end
         end
         default: state_in = biu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl          = '0;
      ctrl.op       = biu_pkg::MUL_NONE;
      ctrl.k        = k_ff;
      ctrl.ch       = ch_ff;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         biu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.start = req_tvalid && opcode == biu_pkg::OPC_QUERY;
            ctrl.wr    = req_tvalid && opcode == biu_pkg::OPC_WRITE;
         end
         biu_pkg::ST_MAPX: ctrl.op = biu_pkg::MUL_POSX;
         biu_pkg::ST_MAPY: ctrl.op = biu_pkg::MUL_POSY;
         biu_pkg::ST_WGT:  ctrl.op = biu_pkg::MUL_WGT;
         biu_pkg::ST_TERM: ctrl.op = biu_pkg::MUL_TERM;
         biu_pkg::ST_DONE: begin
            ctrl.load_out = load;
            if (load) begin
               rsp_tvalid_in = 1'b1;
            end
         end
         default: ctrl.op = biu_pkg::MUL_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= biu_pkg::ST_IDLE;
         k_ff          <= 2'd0;
         ch_ff         <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         ch_ff         <= ch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

/* hdl/biu_datapath.sv */
module biu_datapath #(
   parameter int MAX_WIDTH  = biu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = biu_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = biu_pkg::DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  biu_pkg::ctrl_type               ctrl,
   input  logic [11:0]                     req_column,
   input  logic [11:0]                     req_row,
   input  logic [23:0]                     req_pixel,
   input  logic                            csr_we,
   input  logic [biu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [biu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            pending,
   output logic [7:0]                      red_out,
   output logic [7:0]                      green_out,
   output logic [7:0]                      blue_out
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int QW    = FRAC_BITS + 1;          // weight, up to ONE
   localparam int MA    = (QW > 12) ? QW : 12;
   localparam int MB    = (QW > 16) ? QW : 16;
   localparam int PW    = MA + MB;
   localparam int POSW  = 28;                     // 12-bit coord times 16-bit step
   localparam int ONE   = 1 << FRAC_BITS;
   localparam int HALF  = 1 << (FRAC_BITS - 1);

   // configuration
   logic [8:0]  src_width_ff, src_height_ff;
   logic [15:0] col_step_ff, row_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= biu_pkg::RST_SOURCE_WIDTH;
         src_height_ff <= biu_pkg::RST_SOURCE_HEIGHT;
         col_step_ff   <= biu_pkg::RST_COL_STEP;
         row_step_ff   <= biu_pkg::RST_ROW_STEP;
      end else if (csr_we) begin
         case (csr_index)
            biu_pkg::REG_SOURCE_WIDTH:  src_width_ff  <= csr_wdata[8:0];
            biu_pkg::REG_SOURCE_HEIGHT: src_height_ff <= csr_wdata[8:0];
            biu_pkg::REG_COL_STEP:      col_step_ff   <= csr_wdata;
            biu_pkg::REG_ROW_STEP:      row_step_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // last usable column and row after clamping the size to [2, MAX]
   logic [POSW-1:0] wx, hy, last_x, last_y;

   always_comb begin
      wx = POSW'(src_width_ff);
      hy = POSW'(src_height_ff);
      if (wx < POSW'(2)) begin
         wx = POSW'(2);
      end else if (wx > POSW'(MAX_WIDTH)) begin
         wx = POSW'(MAX_WIDTH);
      end
      if (hy < POSW'(2)) begin
         hy = POSW'(2);
      end else if (hy > POSW'(MAX_HEIGHT)) begin
         hy = POSW'(MAX_HEIGHT);
      end
      last_x = wx - POSW'(1);
      last_y = hy - POSW'(1);
   end

   // query coordinates
   logic [11:0] col_ff, row_ff;

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
   end

   // mapped position, fractions, weights, neighbors, sums
   logic [CW-1:0]        c0_ff, c1_ff;
   logic [RW-1:0]        r0_ff, r1_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic [QW-1:0]        wt_ff [4];
   logic [23:0]          px_ff [4];
   logic [9:0]           acc_ff [3];

   // shared multiplier
   logic [MA-1:0]       mul_a;
   logic [MB-1:0]       mul_b;
   logic [PW-1:0]       prod_ff;
   biu_pkg::mul_op_type prod_op_ff;
   logic [1:0]          prod_k_ff, prod_ch_ff;
   logic [QW-1:0]       fx_q, fy_q, omfx, omfy;
   logic [23:0]         px_sel;
   logic [7:0]          chan;

   assign fx_q   = QW'(fx_ff);
   assign fy_q   = QW'(fy_ff);
   assign omfx   = QW'(ONE) - fx_q;
   assign omfy   = QW'(ONE) - fy_q;
   assign px_sel = px_ff[ctrl.k];

   always_comb begin
      case (ctrl.ch)
         2'd0:    chan = px_sel[23:16];
         2'd1:    chan = px_sel[15:8];
         default: chan = px_sel[7:0];
      endcase
   end

   always_comb begin
      case (ctrl.op)
         biu_pkg::MUL_POSX: begin
            mul_a = MA'(col_ff);
            mul_b = MB'(col_step_ff);
         end
         biu_pkg::MUL_POSY: begin
            mul_a = MA'(row_ff);
            mul_b = MB'(row_step_ff);
         end
         biu_pkg::MUL_WGT: begin
            mul_a = MA'(ctrl.k[0] ? fx_q : omfx);
            mul_b = MB'(ctrl.k[1] ? fy_q : omfy);
         end
         biu_pkg::MUL_TERM: begin
            mul_a = MA'(wt_ff[ctrl.k]);
            mul_b = MB'(chan);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_op_ff <= biu_pkg::MUL_NONE;
      end else begin
         prod_op_ff <= ctrl.op;
      end
      prod_ff    <= PW'(mul_a) * PW'(mul_b);
      prod_k_ff  <= ctrl.k;
      prod_ch_ff <= ctrl.ch;
   end

   assign pending = prod_op_ff != biu_pkg::MUL_NONE;

   // edge clamp of a mapped position
   logic [POSW-1:0]      ip, last_sel, idx, idx_nxt;
   logic [FRAC_BITS-1:0] frac;
   logic [PW:0]          rnd;

   always_comb begin
      last_sel = (prod_op_ff == biu_pkg::MUL_POSY) ? last_y : last_x;
      ip       = POSW'(prod_ff[POSW-1:FRAC_BITS]);
      if (ip >= last_sel) begin
         idx     = last_sel;
         idx_nxt = last_sel;
         frac    = '0;
      end else begin
         idx     = ip;
         idx_nxt = ip + POSW'(1);
         frac    = prod_ff[FRAC_BITS-1:0];
      end
   end

   assign rnd = (PW + 1)'(prod_ff) + (PW + 1)'(HALF);

   always_ff @(posedge clock) begin
      case (prod_op_ff)
         biu_pkg::MUL_POSX: begin
            c0_ff <= idx[CW-1:0];
            c1_ff <= idx_nxt[CW-1:0];
            fx_ff <= frac;
         end
         biu_pkg::MUL_POSY: begin
            r0_ff <= idx[RW-1:0];
            r1_ff <= idx_nxt[RW-1:0];
            fy_ff <= frac;
         end
         biu_pkg::MUL_WGT: wt_ff[prod_k_ff] <= rnd[FRAC_BITS +: QW];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
      end else if (prod_op_ff == biu_pkg::MUL_TERM) begin
         acc_ff[prod_ch_ff] <= acc_ff[prod_ch_ff] + 10'(rnd[FRAC_BITS +: 8]);
      end
   end

   // frame store: write on a write beat, one neighbor read per weight cycle
   logic [CW-1:0] a_col;
   logic [RW-1:0] a_row;
   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [23:0]   ram_rdata;
   logic          rd_valid_ff;
   logic [1:0]    rd_k_ff;

   assign ram_we = ctrl.wr && ({1'b0, req_column} < 13'(MAX_WIDTH))
                           && ({1'b0, req_row} < 13'(MAX_HEIGHT));

   always_comb begin
      if (ctrl.wr) begin
         a_col = req_column[CW-1:0];
         a_row = req_row[RW-1:0];
      end else begin
         a_col = ctrl.k[0] ? c1_ff : c0_ff;
         a_row = ctrl.k[1] ? r1_ff : r0_ff;
      end
   end

   assign ram_addr = AW'(a_row) * AW'(MAX_WIDTH) + AW'(a_col);

   biu_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
   ) u_frame (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_pixel),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.op == biu_pkg::MUL_WGT;
      end
      rd_k_ff <= ctrl.k;
      if (rd_valid_ff) begin
         px_ff[rd_k_ff] <= ram_rdata;
      end
   end

   // result register, saturated at 255
   logic [7:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         red_ff   <= (acc_ff[0] > 10'd255) ? 8'd255 : acc_ff[0][7:0];
         green_ff <= (acc_ff[1] > 10'd255) ? 8'd255 : acc_ff[1][7:0];
         blue_ff  <= (acc_ff[2] > 10'd255) ? 8'd255 : acc_ff[2][7:0];
      end
   end

   assign red_out   = red_ff;
   assign green_out = green_ff;
   assign blue_out  = blue_ff;

endmodule

/* hdl/biu_checker.sv */
module biu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [0:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [biu_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a query occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser[0] == biu_pkg::OPC_QUERY |=> !req_tready)
      else $error("input taken while a query is in work");

   // a write leaves the block ready
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_tuser[0] == biu_pkg::OPC_WRITE |=> req_tready)
      else $error("write stalled the input");

   // a new result only ends a query in work
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a query in work");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind bilinear_image_upscaler_core biu_checker u_biu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
